// ===== sv/fat12_table_byte_synthesizer_unit_defines.svh =====
// Assertion macros for the FAT12 table byte synthesizer.
`ifndef FAT12_TABLE_BYTE_SYNTHESIZER_UNIT_DEFINES_SVH
`define FAT12_TABLE_BYTE_SYNTHESIZER_UNIT_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define F12_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check with the consequent taken in the cycle after the antecedent.
`define F12_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/f12tbs_pkg.sv =====
// Package: widths, entry codes, register indexes and the cluster entry function.
`default_nettype none

package f12tbs_pkg;

    localparam int unsigned OFFSET_W      = 13;
    localparam int unsigned ENTRY_W       = 12;
    localparam int unsigned CLUSTER_W     = OFFSET_W;
    localparam int unsigned SUM_W         = ENTRY_W + 2;
    localparam int unsigned SECTOR_BYTES  = 512;
    localparam int unsigned TABLE_SECTORS_DEF = 16;

    // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for every x below 2**OFFSET_W
    localparam int unsigned DIV3_SHIFT    = OFFSET_W;
    localparam int unsigned DIV3_MUL      = ((2 ** OFFSET_W) + 2) / 3;
    localparam int unsigned DIV3_MUL_W    = $clog2(DIV3_MUL + 1);
    localparam int unsigned QUOT_W        = OFFSET_W - 1;

    localparam logic [ENTRY_W-1:0] ENTRY_MEDIA = 12'hFF8;
    localparam logic [ENTRY_W-1:0] ENTRY_END   = 12'hFFF;
    localparam logic [ENTRY_W-1:0] ENTRY_FREE  = 12'h000;

    localparam logic [ENTRY_W-1:0] FEED_RESET  = 12'd1;

    typedef enum logic [1:0] {
        REG_FEED  = 2'd0,
        REG_FILES = 2'd1,
        REG_OWN   = 2'd2
    } cfg_reg_t;

    typedef logic [ENTRY_W-1:0] entry_t;

    // Allocation table entry of cluster c under the current layout.
    function automatic entry_t cluster_entry(
        input logic [CLUSTER_W-1:0] c,
        input logic [ENTRY_W-1:0]   feed,
        input logic [ENTRY_W-1:0]   files,
        input logic                 own
    );
        logic [SUM_W-1:0] cw;
        logic [SUM_W-1:0] feed_end;
        logic [SUM_W-1:0] first_file;
        logic [SUM_W-1:0] file_end;
        logic [CLUSTER_W-1:0] link;
        entry_t           e;
        cw         = SUM_W'(c);
        feed_end   = SUM_W'(feed) + SUM_W'(1);
        first_file = SUM_W'(feed) + SUM_W'(4);
        file_end   = first_file + SUM_W'(files);
        link       = c + CLUSTER_W'(1);
        if (c == '0)
            e = ENTRY_MEDIA;
        else if (c == CLUSTER_W'(1))
            e = ENTRY_END;
        else if (cw < feed_end)
            e = link[ENTRY_W-1:0];
        else if (cw == feed_end)
            e = ENTRY_END;
        else if (cw == SUM_W'(feed) + SUM_W'(2))
            e = ENTRY_END;
        else if (cw == SUM_W'(feed) + SUM_W'(3))
            e = own ? ENTRY_END : ENTRY_FREE;
        else if (cw >= first_file && cw < file_end)
            e = ENTRY_END;
        else
            e = ENTRY_FREE;
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fat12_table_byte_synthesizer_unit.sv =====
// FAT12 table byte synthesizer: three-stage pipeline from table offset to table byte.
//
// Usage:
//   Input channel (in_valid / in_stall / table_offset) takes one byte offset per item.
//   Output channel (out_valid / out_stall / table_byte) returns the packed FAT12 byte.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes feed_clusters,
//   file_count and own_present; cfg_ready is always high. Write only when the block
//   holds no item.
// Stages: divide by 3, entry lookup, pack, each ending in its own register; out_valid
//   is the valid bit of the pack stage.
// Throughput: one item per cycle while out_stall is low; the stage depth is set by the
//   divide-by-3 multiply and by the entry compare chain.
// Offsets at or beyond TABLE_SECTORS * 512 return 0.
// Reset: all stages empty, feed_clusters = 1, file_count = 0, own_present = 0.
// Stall: while out_stall holds, the output item stays put; empty stages still fill,
//   and in_stall rises only when all three stages hold an item.
`default_nettype none

module fat12_table_byte_synthesizer_unit #(
    parameter int unsigned TABLE_SECTORS = f12tbs_pkg::TABLE_SECTORS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [f12tbs_pkg::OFFSET_W-1:0]     table_offset,
    // output channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [7:0]                               table_byte,
    // config channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [f12tbs_pkg::ENTRY_W-1:0]      cfg_data
);
    import f12tbs_pkg::*;

    `include "fat12_table_byte_synthesizer_unit_defines.svh"

    localparam int unsigned TableBytes = TABLE_SECTORS * SECTOR_BYTES;
    localparam int unsigned ProdW      = OFFSET_W + DIV3_MUL_W;

    // configuration registers
    logic [ENTRY_W-1:0] feed_reg;
    logic [ENTRY_W-1:0] files_reg;
    logic               own_reg;

    // stage 1: quotient
    logic                s1_valid_reg;
    logic [OFFSET_W-1:0] s1_offset_reg;
    logic [QUOT_W-1:0]   s1_quot_reg;
    logic                s1_inrange_reg;

    // stage 2: entries and remainder
    logic                s2_valid_reg;
    entry_t              s2_e0_reg;
    entry_t              s2_e1_reg;
    logic [1:0]          s2_r_reg;

    // stage 3: output
    logic                s3_valid_reg;
    logic [7:0]          s3_byte_reg;

    logic load1, load2, load3;
    logic [ProdW-1:0]     prod;
    logic [QUOT_W-1:0]    quot_next;
    logic                 inrange_next;
    logic [OFFSET_W-1:0]  rem_full;
    logic [CLUSTER_W-1:0] c0, c1;
    entry_t               e0_next, e1_next;
    logic [7:0]           byte_next;

    // config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_reg  <= FEED_RESET;
            files_reg <= '0;
            own_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FEED:  feed_reg  <= cfg_data;
                REG_FILES: files_reg <= cfg_data;
                REG_OWN:   own_reg   <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    // flow control: a stage loads when empty or when its item moves on
    assign load3    = !s3_valid_reg || !out_stall;
    assign load2    = !s2_valid_reg || load3;
    assign load1    = !s1_valid_reg || load2;
    assign in_stall = !load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1) s1_valid_reg <= in_valid;
            if (load2) s2_valid_reg <= s1_valid_reg;
            if (load3) s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: k = offset / 3 by reciprocal multiply, range check
    always_comb
    begin
        prod         = ProdW'(table_offset) * ProdW'(DIV3_MUL);
        quot_next    = prod[DIV3_SHIFT +: QUOT_W];
        inrange_next = (SUM_W'(table_offset) < SUM_W'(TableBytes));
    end

    always_ff @(posedge clk)
    begin
        if (load1 && in_valid)
        begin
            s1_offset_reg  <= table_offset;
            s1_quot_reg    <= quot_next;
            s1_inrange_reg <= inrange_next;
        end
    end

    // stage 2: remainder and the two cluster entries
    always_comb
    begin
        rem_full = s1_offset_reg - {s1_quot_reg, 1'b0} - OFFSET_W'(s1_quot_reg);
        c0       = {s1_quot_reg, 1'b0};
        c1       = {s1_quot_reg, 1'b1};
        e0_next  = ENTRY_FREE;
        e1_next  = ENTRY_FREE;
        if (s1_inrange_reg)
        begin
            e0_next = cluster_entry(c0, feed_reg, files_reg, own_reg);
            e1_next = cluster_entry(c1, feed_reg, files_reg, own_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2 && s1_valid_reg)
        begin
            s2_e0_reg <= e0_next;
            s2_e1_reg <= e1_next;
            s2_r_reg  <= rem_full[1:0];
        end
    end

    // stage 3: FAT12 packing of the entry pair
    always_comb
    begin
        case (s2_r_reg)
            2'd0:    byte_next = s2_e0_reg[7:0];
            2'd1:    byte_next = {s2_e1_reg[3:0], s2_e0_reg[11:8]};
            default: byte_next = s2_e1_reg[11:4];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load3 && s2_valid_reg)
            s3_byte_reg <= byte_next;
    end

    assign out_valid  = s3_valid_reg;
    assign table_byte = s3_byte_reg;

    // checks
    `F12_ASSERT(a_stall_only_full, in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_stall), "input stalled with an empty stage")
    `F12_ASSERT(a_rem_range, s2_valid_reg |-> (s2_r_reg != 2'd3), "offset remainder out of range")
    `F12_ASSERT_NEXT(a_past_table_free, load2 && s1_valid_reg && !s1_inrange_reg, s2_e0_reg == ENTRY_FREE && s2_e1_reg == ENTRY_FREE, "offset past table gave nonzero entries")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the FAT12 table byte synthesizer: layouts, table offsets, checks.

module tb_top;
    import f12tbs_pkg::*;

    localparam int unsigned TABLE_SECTORS = TABLE_SECTORS_DEF;
    localparam int unsigned TABLE_BYTES   = TABLE_SECTORS * SECTOR_BYTES;
    localparam int          PIPE_DEPTH    = 3;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          RANDOM_PHASES = 10;
    localparam int          PHASE_ITEMS   = 133;
    localparam logic [1:0]  REG_SPARE     = 2'd3;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [OFFSET_W-1:0] table_offset;
    logic                out_valid;
    logic                out_stall;
    logic [7:0]          table_byte;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [ENTRY_W-1:0]  cfg_data;

    // Bench copy of the layout registers
    logic [ENTRY_W-1:0]  feed_now;
    logic [ENTRY_W-1:0]  files_now;
    logic                own_now;

    logic [7:0]          expected_bytes[$];
    logic [OFFSET_W-1:0] expected_offsets[$];
    int                  offsets_sent;
    int                  bytes_checked;
    int                  layouts_used;
    int                  mismatches;
    bit                  hold_req;

    logic [7:0]          want_byte;
    logic [OFFSET_W-1:0] want_offset;

    fat12_table_byte_synthesizer_unit #(
        .TABLE_SECTORS(TABLE_SECTORS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .table_offset (table_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .table_byte   (table_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Entry of one cluster under the current layout
    function automatic logic [ENTRY_W-1:0] entry_of(input int unsigned c);
        int unsigned f;
        int unsigned files_start;
        f = feed_now;
        files_start = f + 4;
        if (c == 0)
            return ENTRY_MEDIA;
        if (c == 1)
            return ENTRY_END;
        if (c < f + 1)
            return ENTRY_W'(c + 1);    // chain link, wraps at 12 bits
        if (c == f + 1 || c == f + 2)
            return ENTRY_END;          // end of feed, then the directory
        if (c == f + 3)
            return own_now ? ENTRY_END : ENTRY_FREE;
        if (c >= files_start && c < files_start + files_now)
            return ENTRY_END;
        return ENTRY_FREE;
    endfunction

    // Packed table byte at one offset
    function automatic logic [7:0] table_byte_of(input logic [OFFSET_W-1:0] off);
        int unsigned  k;
        int unsigned  r;
        logic [ENTRY_W-1:0] e0;
        logic [ENTRY_W-1:0] e1;
        if (off >= TABLE_BYTES)
            return 8'h00;
        k  = off / 3;
        r  = off % 3;
        e0 = entry_of(2 * k);
        e1 = entry_of(2 * k + 1);
        case (r)
            0:       return e0[7:0];
            1:       return {e1[3:0], e0[11:8]};
            default: return e1[11:4];
        endcase
    endfunction

    // Offset biased toward the layout boundaries and the table ends
    function automatic logic [OFFSET_W-1:0] pick_offset();
        int unsigned base;
        int unsigned c;
        int unsigned off;
        case ($urandom_range(0, 4))
            0, 1:
                return OFFSET_W'($urandom);
            2, 3:
            begin
                case ($urandom_range(0, 3))
                    0:       base = feed_now + 1;
                    1:       base = feed_now + 3;
                    2:       base = feed_now + 4 + files_now;
                    default: base = 4095;
                endcase
                c = (base >= 3) ? base + $urandom_range(0, 5) - 3 : $urandom_range(0, 5);
                off = (c / 2) * 3 + $urandom_range(0, 2);
                return (off < (1 << OFFSET_W)) ? OFFSET_W'(off) : OFFSET_W'($urandom);
            end
            default:
                return $urandom_range(0, 1) ? OFFSET_W'($urandom_range(0, 11))
                                            : OFFSET_W'($urandom_range(8180, 8191));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 20)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Offer one offset; returns at the edge that accepts it
    task automatic send_offset(input logic [OFFSET_W-1:0] off);
        in_valid     <= 1'b1;
        table_offset <= off;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_bytes.push_back(table_byte_of(off));
        expected_offsets.push_back(off);
        offsets_sent++;
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // One register write; valid stays up for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [ENTRY_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_FEED:  feed_now  = data;
            REG_FILES: files_now = data;
            REG_OWN:   own_now   = data[0];
            default:   ;
        endcase
    endtask

    task automatic set_layout(input logic [ENTRY_W-1:0] feed, input logic [ENTRY_W-1:0] files,
                              input logic own, input bit poke_spare);
        if (poke_spare)
            write_reg(REG_SPARE, ENTRY_W'($urandom));
        write_reg(REG_FEED, feed);
        write_reg(REG_FILES, files);
        // upper data bits are don't-care for the presence flag
        write_reg(REG_OWN, {(ENTRY_W-1)'($urandom), own});
        cfg_valid <= 1'b0;
        layouts_used++;
    endtask

    task automatic send_burst_train(input int n);
        int left;
        int burst;
        int gap;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            if (burst > left)
                burst = left;
            repeat (burst) send_offset(pick_offset());
            left -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Reset layout: media, reserved, a one-cluster feed, directory, free own cluster
    task automatic test_reset_layout();
        for (int i = 0; i < 6; i++)
            send_offset(OFFSET_W'(i));
        send_offset(OFFSET_W'(TABLE_BYTES - 1));
        drain();
    endtask

    // Empty feed, wrapped chain link, file run past cluster 4095, top offsets
    task automatic test_layout_corners();
        set_layout(12'd0, 12'd2, 1'b1, 1'b0);
        for (int i = 0; i < 6; i++)
            send_offset(OFFSET_W'(i));
        drain();
        set_layout(12'd4095, 12'd4095, 1'b1, 1'b1);
        send_offset(13'd6141);
        send_offset(13'd6142);
        send_offset(13'd6143);
        send_offset(13'd8189);
        send_offset(13'd8190);
        send_offset(13'd8191);
        drain();
        set_layout(12'd1, 12'd0, 1'b1, 1'b0);
        send_offset(13'd3);
        send_offset(13'd4);
        send_offset(13'd5);
        drain();
    endtask

    // Receiver holds off while offsets keep coming, so the pipe fills and stalls
    task automatic test_output_hold_off();
        set_layout(12'($urandom_range(1, 40)), 12'($urandom_range(0, 40)), 1'b1, 1'b0);
        hold_req = 1'b1;
        repeat (24) send_offset(pick_offset());
        drain();
    endtask

    task automatic test_random_layouts();
        logic [ENTRY_W-1:0] feed;
        logic [ENTRY_W-1:0] files;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    feed  = 12'd4095;
                    files = 12'd4095;
                end
                1:
                begin
                    feed  = 12'd0;
                    files = 12'd0;
                end
                2:
                begin
                    feed  = 12'd1;
                    files = 12'd4095;
                end
                default:
                begin
                    feed  = $urandom_range(0, 1) ? 12'($urandom_range(0, 30)) : 12'($urandom);
                    files = $urandom_range(0, 1) ? 12'($urandom_range(0, 30)) : 12'($urandom);
                end
            endcase
            set_layout(feed, files, 1'($urandom), phase == 3);
            send_burst_train(PHASE_ITEMS);
            drain();
        end
    endtask

    // Receiver stall pattern, plus the long hold-off on request
    initial
    begin : rx_pattern
        rx_mode_t mode;
        int       left;
        int       held;
        out_stall <= 1'b0;
        mode = RX_FREE;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    RX_FREE:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:  out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Compare each delivered byte with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("table byte %02h with no offset pending", table_byte));
            else
            begin
                want_byte   = expected_bytes.pop_front();
                want_offset = expected_offsets.pop_front();
                if (table_byte !== want_byte)
                    report_mismatch($sformatf("offset %0d: table_byte %02h, predicted %02h",
                                              want_offset, table_byte, want_byte));
                bytes_checked++;
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     <= 1'b0;
        table_offset <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_FEED;
        cfg_data     <= '0;
        feed_now     = FEED_RESET;
        files_now    = '0;
        own_now      = 1'b0;
        offsets_sent  = 0;
        bytes_checked = 0;
        layouts_used  = 1;
        mismatches    = 0;
        hold_req      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_layout();
        test_layout_corners();
        test_output_hold_off();
        test_random_layouts();
        drain();

        $display("Offsets sent: %0d, table bytes checked: %0d, layouts: %0d, mismatches: %0d",
                 offsets_sent, bytes_checked, layouts_used, mismatches);
        $display("Covered empty and full feeds, wrapped links, long file runs, stalls and gaps");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
